// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/utf8d_pkg.sv =====
// Types, constants and helper functions of the UTF-8 byte stream decoder.
package utf8d_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam logic [15:0] MAX_CP_RESET = 16'hFFFF;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] cp;
    logic [15:0] cnt;
    logic        eom;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  // Form length from a lead byte with the top bit set; zero flags a bad lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    begin
      if (b < 8'hC0)      n = 3'd0;
      else if (b < 8'hE0) n = 3'd2;
      else if (b < 8'hF0) n = 3'd3;
      else if (b < 8'hF8) n = 3'd4;
      else if (b < 8'hFC) n = 3'd5;
      else if (b < 8'hFE) n = 3'd6;
      else                n = 3'd0;
      return n;
    end
  endfunction

  // Payload bits kept from a lead byte of an n-byte form.
  function automatic logic [7:0] lead_mask(input logic [2:0] n);
    logic [7:0] m;
    begin
      m = 8'hFF >> (4'(n) + 4'd1);
      return m;
    end
  endfunction

endpackage

// ===== sv/utf8_byte_stream_decoder_unit.sv =====
// Top level of the UTF-8 byte stream decoder.
//
// Decodes a message of UTF-8 bytes, one byte per input word with a last
// mark, into code points. Lead bytes of the original one- to six-byte forms
// are taken with no overlong or surrogate checks. Each finished character
// gives a point word (kind 0); the last byte of a clean message adds a done
// word (kind 1) carrying the count. A stray continuation byte, 0xFE/0xFF,
// a missing continuation, a message cut short, or starting a character once
// cfg max_code_points characters were produced gives one error word
// (kind 2) that ends the message; the rest of that message's bytes are
// dropped without output. Done and error words carry end_of_message.
// Timing: a byte is registered at the input, decoded in the next cycle and
// its words land in an eight-entry result queue, so the first word of a byte
// shows on out_* once the queue holds it. One byte is taken per cycle while
// in_ready is high; the output drains one word per cycle while out_ready is
// high. A last byte closing a character gives two words. in_ready drops when
// the queue cannot hold two words for both the byte in decode and a new one.
// Write cfg only while the block is idle.
module utf8_byte_stream_decoder_unit #(
  parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [30:0] out_code_point,
  output logic [15:0] out_decoded_count,
  output logic        out_end_of_message,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  localparam int AW = utf8d_pkg::FIFO_AW;

  // capacity register
  logic [15:0] max_r;

  // input register stage
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  utf8d_pkg::dec_out_t dec;
  utf8d_pkg::res_t     head;
  logic [AW:0]         q_cnt;
  logic [AW+1:0]       q_need;
  logic                q_ne;
  logic                in_acc;

  // Reserve two slots for the byte in decode and two for a new one.
  assign q_need   = (AW+2)'(q_cnt) + (s1_v_r ? (AW+2)'(2) : '0);
  assign in_ready = (q_need <= (AW+2)'(utf8d_pkg::FIFO_DEPTH - 2));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= utf8d_pkg::MAX_CP_RESET;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_r <= cfg_write_data;
      end
      s1_v_r <= in_acc;
    end
  end

  // payload: hold unless a new word is taken
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  utf8d_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (s1_v_r),
    .in_b    (s1_byte_r),
    .in_last (s1_last_r),
    .max_cp  (max_r),
    .dout    (dec)
  );

  utf8d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dec),
    .pop       (out_ready),
    .head      (head),
    .not_empty (q_ne),
    .count     (q_cnt)
  );

  assign out_valid          = q_ne;
  assign out_result_kind    = head.kind;
  assign out_code_point     = head.cp;
  assign out_decoded_count  = head.cnt;
  assign out_end_of_message = head.eom;

endmodule

// ===== sv/utf8d_core.sv =====
// Per-byte decode step with the message state registers.
module utf8d_core #(
  parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  input  logic [7:0]          in_b,
  input  logic                in_last,
  input  logic [15:0]         max_cp,
  output utf8d_pkg::dec_out_t dout
);

  logic [2:0]            need_r, need_nxt;
  logic [30:0]           part_r, part_nxt;
  logic [COUNT_BITS-1:0] prod_r, prod_nxt;
  logic                  drop_r, drop_nxt;

  logic [COUNT_BITS-1:0] prod_inc;
  logic                  cap_full;

  assign prod_inc = prod_r + COUNT_BITS'(1);
  assign cap_full = (32'(prod_r) >= 32'(max_cp)) || (&prod_r);

  always_comb begin
    logic [2:0]       n;
    logic             err;
    logic             emit_pt;
    logic [30:0]      pt_val;
    logic [30:0]      shifted;
    logic [31:0]      cnt_ext;
    utf8d_pkg::res_t  rp;
    utf8d_pkg::res_t  rt;
    logic             has_tail;
    need_nxt = need_r;
    part_nxt = part_r;
    prod_nxt = prod_r;
    drop_nxt = drop_r;
    n        = 3'd0;
    err      = 1'b0;
    emit_pt  = 1'b0;
    pt_val   = '0;
    shifted  = {part_r[24:0], in_b[5:0]};
    cnt_ext  = '0;
    rp       = '0;
    rt       = '0;
    has_tail = 1'b0;
    dout     = '0;
    if (in_v) begin
      if (drop_r) begin
        // drop bytes until the one marked last
        if (in_last) begin
          need_nxt = '0;
          part_nxt = '0;
          prod_nxt = '0;
          drop_nxt = 1'b0;
        end
      end else begin
        if (need_r == 3'd0) begin
          if (cap_full) begin
            err = 1'b1;
          end else if (!in_b[7]) begin
            emit_pt  = 1'b1;
            pt_val   = 31'(in_b);
            prod_nxt = prod_inc;
          end else begin
            n = utf8d_pkg::lead_len(in_b);
            if (n < 3'd2) begin
              err = 1'b1;
            end else begin
              part_nxt = 31'(in_b & utf8d_pkg::lead_mask(n));
              need_nxt = n - 3'd1;
            end
          end
        end else begin
          if (in_b[7:6] != 2'b10) begin
            err = 1'b1;
          end else begin
            need_nxt = need_r - 3'd1;
            if (need_r == 3'd1) begin
              emit_pt  = 1'b1;
              pt_val   = shifted;
              part_nxt = '0;
              prod_nxt = prod_inc;
            end else begin
              part_nxt = shifted;
            end
          end
        end
        // message cut short inside a character
        if (!err && in_last && (need_nxt != 3'd0)) begin
          err = 1'b1;
        end
        cnt_ext   = 32'(prod_nxt);
        rp.kind   = utf8d_pkg::KIND_POINT;
        rp.cp     = pt_val;
        if (err) begin
          has_tail = 1'b1;
          rt.kind  = utf8d_pkg::KIND_ERROR;
          rt.eom   = 1'b1;
        end else if (in_last) begin
          has_tail = 1'b1;
          rt.kind  = utf8d_pkg::KIND_DONE;
          rt.cnt   = cnt_ext[15:0];
          rt.eom   = 1'b1;
        end
        if (err || in_last) begin
          need_nxt = '0;
          part_nxt = '0;
          prod_nxt = '0;
          drop_nxt = err && !in_last;
        end
        dout.n  = {1'b0, emit_pt} + {1'b0, has_tail};
        dout.r0 = emit_pt ? rp : rt;
        dout.r1 = rt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= '0;
      part_r <= '0;
      prod_r <= '0;
      drop_r <= 1'b0;
    end else begin
      need_r <= need_nxt;
      part_r <= part_nxt;
      prod_r <= prod_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ===== sv/utf8d_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one.
module utf8d_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  utf8d_pkg::dec_out_t push,
  input  logic              pop,
  output utf8d_pkg::res_t   head,
  output logic              not_empty,
  output logic [utf8d_pkg::FIFO_AW:0] count
);

  localparam int AW = utf8d_pkg::FIFO_AW;

  utf8d_pkg::res_t mem_r [utf8d_pkg::FIFO_DEPTH];
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] wr_p1;
  logic          do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign wr_p1     = wr_r + AW'(1);
  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  always_comb begin
    rd_nxt  = do_pop ? rd_r + AW'(1) : rd_r;
    wr_nxt  = wr_r + AW'(push.n);
    cnt_nxt = cnt_r + (AW+1)'(push.n) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/utf8d_checker.sv =====
// Port-level checker for the UTF-8 byte stream decoder, bound to the top.
`include "assert_macros.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [30:0] out_code_point,
  input logic [15:0] out_decoded_count,
  input logic        out_end_of_message,
  input logic        cfg_write_en,
  input logic [15:0] cfg_write_data
);

  // Only done and error words close a message.
  `ASSERT_IMPLY(a_eom_kind, clk, rst_n, out_valid, out_end_of_message == (out_result_kind != utf8d_pkg::KIND_POINT))

  // Non-point words carry a zero code point.
  `ASSERT_IMPLY(a_cp_zero, clk, rst_n, out_valid && (out_result_kind != utf8d_pkg::KIND_POINT), out_code_point == 31'd0)

  // Only done words carry a count.
  `ASSERT_IMPLY(a_cnt_zero, clk, rst_n, out_valid && (out_result_kind != utf8d_pkg::KIND_DONE), out_decoded_count == 16'd0)

  // A stalled result word keeps its kind and code point.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_kind) && $stable(out_code_point))

endmodule

bind utf8_byte_stream_decoder_unit utf8d_checker u_chk (.*);

// ===== bench/utf8_word_checker.sv =====
// Checker for the UTF-8 decoder: predicts the result words of each byte and compares them.
`timescale 1ns / 1ps
module utf8_word_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_result_kind,
  input  logic [30:0] out_code_point,
  input  logic [15:0] out_decoded_count,
  input  logic        out_end_of_message,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  output int          mismatches,
  output int          words_pending
);

  utf8d_pkg::res_t expected_words[$];
  logic [15:0] cap;
  logic [2:0]  conts_left;
  logic [30:0] partial;
  logic [15:0] produced;
  logic        dropping;
  int          bad_words = 0;
  int          pending_count = 0;

  assign mismatches    = bad_words;
  assign words_pending = pending_count;

  function automatic utf8d_pkg::res_t make_word(input utf8d_pkg::kind_t k,
                                                input logic [30:0] cp,
                                                input logic [15:0] cnt,
                                                input logic eom);
    utf8d_pkg::res_t w;
    w.kind = k;
    w.cp   = cp;
    w.cnt  = cnt;
    w.eom  = eom;
    return w;
  endfunction

  task automatic restart_message();
    conts_left = 3'd0;
    partial    = '0;
    produced   = '0;
    dropping   = 1'b0;
  endtask

  // An error closes the message; drop the rest unless this byte was the last.
  task automatic raise_error(input logic last);
    expected_words.push_back(make_word(utf8d_pkg::KIND_ERROR, '0, '0, 1'b1));
    restart_message();
    dropping = !last;
  endtask

  task automatic emit_point(input logic [30:0] cp);
    expected_words.push_back(make_word(utf8d_pkg::KIND_POINT, cp, '0, 1'b0));
    produced = produced + 16'd1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [2:0] form_len;
    if (dropping) begin
      if (last) restart_message();
      return;
    end
    if (conts_left == 3'd0) begin
      // capacity and counter-full checks come before the byte is examined
      if (produced >= cap || produced == 16'hFFFF) begin
        raise_error(last);
        return;
      end
      if (!b[7]) begin
        emit_point({23'd0, b});
      end else begin
        casez (b)
          8'b110?????: form_len = 3'd2;
          8'b1110????: form_len = 3'd3;
          8'b11110???: form_len = 3'd4;
          8'b111110??: form_len = 3'd5;
          8'b1111110?: form_len = 3'd6;
          default:     form_len = 3'd0;
        endcase
        if (form_len == 3'd0) begin
          raise_error(last);
          return;
        end
        partial    = {23'd0, b & (8'h7F >> form_len)};
        conts_left = form_len - 3'd1;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        raise_error(last);
        return;
      end
      partial    = {partial[24:0], b[5:0]};
      conts_left = conts_left - 3'd1;
      if (conts_left == 3'd0) begin
        emit_point(partial);
        partial = '0;
      end
    end
    if (last) begin
      if (conts_left != 3'd0) begin
        raise_error(last);
        return;
      end
      expected_words.push_back(make_word(utf8d_pkg::KIND_DONE, '0, produced, 1'b1));
      restart_message();
    end
  endtask

  always @(posedge clk) begin : watch
    utf8d_pkg::res_t want;
    if (!rst_n) begin
      expected_words.delete();
      cap = utf8d_pkg::MAX_CP_RESET;
      restart_message();
    end else begin
      if (cfg_write_en) cap = cfg_write_data;
      if (in_valid && in_ready) decode_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          bad_words++;
          $display("%0t: unexpected word kind %0d cp %h count %0d eom %b", $time,
                   out_result_kind, out_code_point, out_decoded_count, out_end_of_message);
        end else begin
          want = expected_words.pop_front();
          if (want.kind != out_result_kind || want.cp != out_code_point ||
              want.cnt != out_decoded_count || want.eom != out_end_of_message) begin
            bad_words++;
            $display("%0t: word mismatch, expected kind %0d cp %h count %0d eom %b,",
                     $time, want.kind, want.cp, want.cnt, want.eom,
                     " got kind %0d cp %h count %0d eom %b",
                     out_result_kind, out_code_point, out_decoded_count,
                     out_end_of_message);
          end
        end
      end
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;

  // Cycles with no accepted word, in or out, before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [30:0] out_code_point;
  logic [15:0] out_decoded_count;
  logic        out_end_of_message;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = 16'd0;

  int          mismatches;
  int          words_pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stuck_cycles = 0;
  logic [7:0]  msg_bytes[$];

  utf8_byte_stream_decoder_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_code_point     (out_code_point),
    .out_decoded_count  (out_decoded_count),
    .out_end_of_message (out_end_of_message),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data)
  );

  // The checker sits beside the block and sees exactly the same pins.
  utf8_word_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_code_point     (out_code_point),
    .out_decoded_count  (out_decoded_count),
    .out_end_of_message (out_end_of_message),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .mismatches         (mismatches),
    .words_pending      (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: decide ready afresh at every falling edge, so stalls land on
  // every phase of the block's work. A zero percentage gives a steady ready.
  always @(negedge clk) out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

  // Watchdog: any accepted word or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one byte; entered and left at a falling edge. Idle cycles go in
  // front of the word, and valid holds with a steady payload until taken.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline empty:
  // bytes in the middle of a character are still in flight with nothing owed.
  task automatic settle();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Only called from settle points, so the block is idle.
  task automatic write_cap(input logic [15:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Append one well-formed character of len bytes with random payload bits.
  task automatic add_char(input int len);
    logic [7:0] lead;
    if (len == 1) begin
      msg_bytes.push_back(8'($urandom_range(0, 127)));
      return;
    end
    lead = 8'hFF << (8 - len);
    lead = lead | (8'($urandom) & (8'h7F >> len));
    msg_bytes.push_back(lead);
    repeat (len - 1) msg_bytes.push_back(8'h80 | (8'($urandom) & 8'h3F));
  endtask

  // ASCII is weighted up a little; the rest spread over every lead form.
  task automatic add_chars(input int count);
    repeat (count) add_char(($urandom_range(0, 9) < 4) ? 1 : $urandom_range(2, 6));
  endtask

  // Start a character and cut it off after its lead or some continuations.
  task automatic add_broken_char();
    int len;
    len = $urandom_range(2, 6);
    add_char(len);
    repeat ($urandom_range(1, len - 1)) void'(msg_bytes.pop_back());
  endtask

  // Mostly clean messages with random content; the rest break in one of the
  // ways the decoder must flag, at random spots, so dropping gets exercised.
  task automatic build_message();
    int         pick;
    logic [7:0] junk;
    msg_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // an occasional long message runs into small capacities
      add_chars(($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5));
    end else if (pick < 70) begin
      // message ends inside a character
      add_chars($urandom_range(0, 4));
      add_broken_char();
    end else if (pick < 80) begin
      // stray continuation or a never-valid lead between characters
      add_chars($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       msg_bytes.push_back(8'h80 | (8'($urandom) & 8'h3F));
        1:       msg_bytes.push_back(8'hFE);
        default: msg_bytes.push_back(8'hFF);
      endcase
      add_chars($urandom_range(0, 4));
    end else if (pick < 90) begin
      // continuation replaced by a byte that is not 10xxxxxx
      add_chars($urandom_range(0, 3));
      add_broken_char();
      junk = 8'($urandom);
      while (junk[7:6] == 2'b10) junk = 8'($urandom);
      msg_bytes.push_back(junk);
      add_chars($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      build_message();
      send_message();
      sent += msg_bytes.size();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, capacity at its reset value.
    msg_bytes = '{8'h00};
    send_message();
    // ASCII top, smallest two-byte form, largest six-byte form
    msg_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    send_message();
    // six-byte form carrying zero
    msg_bytes = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    send_message();
    // stray continuation as lead; the last byte is dropped
    msg_bytes = '{8'h80, 8'h41};
    send_message();
    // bad lead on the last byte, then bad lead in the middle
    msg_bytes = '{8'hFE};
    send_message();
    msg_bytes = '{8'hFF, 8'h00};
    send_message();
    // missing continuation, error lands on the last byte
    msg_bytes = '{8'hE0, 8'h41};
    send_message();
    // cut short
    msg_bytes = '{8'hC3};
    send_message();

    // Zero capacity: the first character already fails.
    settle();
    write_cap(16'd0);
    msg_bytes = '{8'h41};
    send_message();
    // Capacity of one: the second character fails and the rest is dropped.
    settle();
    write_cap(16'd1);
    msg_bytes = '{8'h41, 8'hE2, 8'h82, 8'hAC};
    send_message();

    // Random part: four idling phases, each through three capacity settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int step = 0; step < 3; step++) begin
        settle();
        case (step)
          0:       write_cap(16'($urandom_range(1, 6)));
          1:       write_cap(16'hFFFF);
          default: write_cap(16'($urandom));
        endcase
        run_random(130);
      end
    end

    settle();
    repeat (12) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
